// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the upsampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of prop, sampled on the rising clock edge, off during reset.
`define BRU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent on the following clock edge.
`define BRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bru_pkg.sv -----
package bru_pkg;

   localparam int BLOCK_EDGE = 8;
   localparam int MAX_FACTOR = 4;

   localparam int REG_W    = 3;
   localparam int SAMPLE_W = 8;
   localparam int ADDR_W   = 10;
   localparam int RDATA_W  = 24;

   // configuration register indexes
   localparam logic [2:0] CSR_IN_BLOCKS_H  = 3'd0;
   localparam logic [2:0] CSR_IN_BLOCKS_V  = 3'd1;
   localparam logic [2:0] CSR_OUT_BLOCKS_H = 3'd2;
   localparam logic [2:0] CSR_OUT_BLOCKS_V = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BASE,
      ST_EMIT
   } bru_state_type;

   typedef struct packed {
      logic [REG_W-1:0] ih;
      logic [REG_W-1:0] iv;
      logic [REG_W-1:0] oh;
      logic [REG_W-1:0] fh;
      logic [REG_W-1:0] fv;
   } bru_cfg_type;

   typedef struct packed {
      logic load;
      logic base;
      logic emit;
   } bru_cmd_type;

   typedef struct packed {
      logic no_copy;
      logic last_copy;
      logic out_free;
   } bru_status_type;

   function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
      logic [REG_W-1:0] r;
      r = v;
      if (v == '0) r = REG_W'(1);
      else if (v > REG_W'(MAX_FACTOR)) r = REG_W'(MAX_FACTOR);
      return r;
   endfunction

   // truncating ratio of two clamped block counts (both 1..4)
   function automatic logic [REG_W-1:0] ratio(input logic [REG_W-1:0] num,
                                              input logic [REG_W-1:0] den);
      logic [REG_W-1:0] r;
      r = '0;
      unique case (den)
         3'd1: r = num;
         3'd2: r = num >> 1;
         3'd3: r = (num >= 3'd3) ? 3'd1 : 3'd0;
         default: r = (num == 3'd4) ? 3'd1 : 3'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/bru_csr.sv -----
module bru_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [bru_pkg::REG_W-1:0] csr_data,
   output bru_pkg::bru_cfg_type      cfg
);

   logic [bru_pkg::REG_W-1:0] in_blocks_h_ff, in_blocks_v_ff;
   logic [bru_pkg::REG_W-1:0] out_blocks_h_ff, out_blocks_v_ff;
   logic [bru_pkg::REG_W-1:0] ih, iv, oh, ov;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_blocks_h_ff  <= bru_pkg::REG_W'(1);
         in_blocks_v_ff  <= bru_pkg::REG_W'(1);
         out_blocks_h_ff <= bru_pkg::REG_W'(1);
         out_blocks_v_ff <= bru_pkg::REG_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bru_pkg::CSR_IN_BLOCKS_H:  in_blocks_h_ff  <= csr_data;
            bru_pkg::CSR_IN_BLOCKS_V:  in_blocks_v_ff  <= csr_data;
            bru_pkg::CSR_OUT_BLOCKS_H: out_blocks_h_ff <= csr_data;
            bru_pkg::CSR_OUT_BLOCKS_V: out_blocks_v_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ih = bru_pkg::clamp_reg(in_blocks_h_ff);
   assign iv = bru_pkg::clamp_reg(in_blocks_v_ff);
   assign oh = bru_pkg::clamp_reg(out_blocks_h_ff);
   assign ov = bru_pkg::clamp_reg(out_blocks_v_ff);

   assign cfg.ih = ih;
   assign cfg.iv = iv;
   assign cfg.oh = oh;
   assign cfg.fh = bru_pkg::ratio(oh, ih);
   assign cfg.fv = bru_pkg::ratio(ov, iv);

endmodule

// ----- rtl/bru_ctrl.sv -----
`include "assert_macros.svh"

module bru_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bru_pkg::bru_status_type status,
   output bru_pkg::bru_cmd_type    cmd
);

   bru_pkg::bru_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bru_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         bru_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bru_pkg::ST_BASE;
            end
         end
         bru_pkg::ST_BASE: begin
            cmd.base = 1'b1;
            // a zero factor gives no copies: drop the beat
            state_in = status.no_copy ? bru_pkg::ST_IDLE : bru_pkg::ST_EMIT;
         end
         bru_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_copy) state_in = bru_pkg::ST_IDLE;
            end
         end
         default: state_in = bru_pkg::ST_IDLE;
      endcase
   end

   `BRU_ASSERT(a_emit_in_emit, clock, reset, !cmd.emit || state_ff == bru_pkg::ST_EMIT, "copy issued outside emit state")
   `BRU_ASSERT_NEXT(a_load_to_base, clock, reset, req_tvalid && req_tready, !req_tready, "new beat taken while previous beat busy")

endmodule

// ----- rtl/bru_dp.sv -----
`include "assert_macros.svh"

module bru_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bru_pkg::bru_cmd_type         cmd,
   input  bru_pkg::bru_cfg_type         cfg,
   input  logic [bru_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                         in_start,
   output bru_pkg::bru_status_type      status,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bru_pkg::RDATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser
);

   // position counters
   logic [1:0] block_col_ff, block_row_ff, block_col_in, block_row_in;
   logic [2:0] pixel_col_ff, pixel_row_ff, pixel_col_in, pixel_row_in;
   logic [1:0] bc, br;
   logic [2:0] pc, pr;
   logic       col_wrap, row_wrap;

   // per-beat work registers
   logic [bru_pkg::SAMPLE_W-1:0] sample_ff;
   logic [6:0]                   row0_ff, col0_ff;
   logic                         last_sample_ff;
   logic [bru_pkg::ADDR_W-1:0]   line_ff;
   logic [2:0]                   h_ff, v_ff;

   // output register
   logic                         out_valid_ff;
   logic [bru_pkg::ADDR_W-1:0]   out_addr_ff;
   logic [bru_pkg::SAMPLE_W-1:0] out_value_ff;
   logic                         out_last_ff, out_done_ff;

   logic [7:0]                 row_prod, col_prod;
   logic [9:0]                 base_prod;
   logic [bru_pkg::ADDR_W-1:0] line_base, width;
   logic                       last_sample, h_end;

   // start clears the counters before this beat uses them
   assign bc = in_start ? 2'd0 : block_col_ff;
   assign br = in_start ? 2'd0 : block_row_ff;
   assign pc = in_start ? 3'd0 : pixel_col_ff;
   assign pr = in_start ? 3'd0 : pixel_row_ff;

   assign col_wrap = ({1'b0, bc} + 3'd1) >= cfg.ih;
   assign row_wrap = ({1'b0, br} + 3'd1) >= cfg.iv;
   assign last_sample = row_wrap && col_wrap && (pr == 3'd7) && (pc == 3'd7);

   always_comb begin
      pixel_col_in = pc + 3'd1;
      pixel_row_in = pr;
      block_col_in = bc;
      block_row_in = br;
      if (pc == 3'd7) begin
         pixel_row_in = pr + 3'd1;
         if (pr == 3'd7) begin
            if (col_wrap) begin
               block_col_in = 2'd0;
               block_row_in = row_wrap ? 2'd0 : br + 2'd1;
            end else begin
               block_col_in = bc + 2'd1;
            end
         end
      end
   end

   assign row_prod  = {3'b0, br, pr} * {5'b0, cfg.fv};
   assign col_prod  = {3'b0, bc, pc} * {5'b0, cfg.fh};
   assign base_prod = {3'b0, row0_ff} * {7'b0, cfg.oh};
   assign line_base = {base_prod[6:0], 3'b000} + {3'b0, col0_ff};
   assign width     = {4'b0, cfg.oh, 3'b000};

   assign h_end            = (h_ff + 3'd1) == cfg.fh;
   assign status.last_copy = h_end && ((v_ff + 3'd1) == cfg.fv);
   assign status.no_copy   = (cfg.fh == 3'd0) || (cfg.fv == 3'd0);
   assign status.out_free  = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_col_ff <= '0;
         block_row_ff <= '0;
         pixel_col_ff <= '0;
         pixel_row_ff <= '0;
         h_ff         <= '0;
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            block_col_ff <= block_col_in;
            block_row_ff <= block_row_in;
            pixel_col_ff <= pixel_col_in;
            pixel_row_ff <= pixel_row_in;
         end
         if (cmd.base) begin
            h_ff <= '0;
            v_ff <= '0;
         end else if (cmd.emit) begin
            if (h_end) begin
               h_ff <= '0;
               v_ff <= v_ff + 3'd1;
            end else begin
               h_ff <= h_ff + 3'd1;
            end
         end
         if (cmd.emit)        out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff      <= in_sample;
         row0_ff        <= row_prod[6:0];
         col0_ff        <= col_prod[6:0];
         last_sample_ff <= last_sample;
      end
      if (cmd.base) begin
         line_ff <= line_base;
      end else if (cmd.emit && h_end) begin
         // advance one raster line for the next vertical copy
         line_ff <= line_ff + width;
      end
      if (cmd.emit) begin
         out_addr_ff  <= line_ff + {7'b0, h_ff};
         out_value_ff <= sample_ff;
         out_last_ff  <= status.last_copy;
         out_done_ff  <= status.last_copy && last_sample_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_value_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   `BRU_ASSERT(a_done_is_last, clock, reset, !(out_valid_ff && out_done_ff) || out_last_ff, "component done without run last")
   `BRU_ASSERT(a_copy_in_range, clock, reset, !cmd.emit || (h_ff < cfg.fh && v_ff < cfg.fv), "copy index beyond factor")

endmodule

// ----- rtl/block_to_raster_replicating_upsampler_core.sv -----
// An accepted sample beat goes to the base state, then to the emit state, where the single
// copy generator in the datapath issues one copy per cycle while the output register is free;
// zero-copy samples go from the base state back to idle. New samples are taken only in idle.
// A finished copy waits in the output register while the next sample is taken.
// Reset (synchronous, active high) sets all four block counts to 1 and clears
// the position counters and the output register.
module block_to_raster_replicating_upsampler_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] sample
   input  logic                        req_tuser,   // [0] start_req
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bru_pkg::RDATA_W-1:0] rsp_tdata,   // [9:0] out_address, [17:10] out_value
   output logic                        rsp_tlast,   // run_last
   output logic                        rsp_tuser,   // [0] component_done
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [bru_pkg::REG_W-1:0]   csr_data
);

   bru_pkg::bru_cfg_type    cfg;
   bru_pkg::bru_cmd_type    cmd;
   bru_pkg::bru_status_type status;

   bru_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bru_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .in_sample  (req_tdata),
      .in_start   (req_tuser),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- test/bru_copy_checker.sv -----
`timescale 1ns / 1ps

module bru_copy_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] sample
   input  logic                        req_tuser,   // [0] start_req
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [bru_pkg::RDATA_W-1:0] rsp_tdata,   // [9:0] out_address, [17:10] out_value
   input  logic                        rsp_tlast,   // run_last
   input  logic                        rsp_tuser,   // [0] component_done
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [bru_pkg::REG_W-1:0]   csr_data,
   output int                          mismatches,
   output int                          outstanding
);
   import bru_pkg::*;

   localparam int PAD_W = RDATA_W - ADDR_W - SAMPLE_W;

   typedef struct {
      logic [ADDR_W-1:0]   address;
      logic [SAMPLE_W-1:0] value;
      logic                run_last;
      logic                done;
   } copy_beat_t;

   copy_beat_t expected_copies[$];

   logic [REG_W-1:0] in_h, in_v, out_h, out_v;
   logic [1:0]       blk_col, blk_row;
   logic [2:0]       pix_row, pix_col;

   function automatic int block_count(input logic [REG_W-1:0] raw);
      if (raw == '0) return 1;
      if (int'(raw) > MAX_FACTOR) return MAX_FACTOR;
      return int'(raw);
   endfunction

   task automatic report_field(input string field, input logic [31:0] expv,
                               input logic [31:0] actv);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, expv, actv);
   endtask

   // Queue every copy of one sample, then step the position counters.
   task automatic predict_copies(input logic [SAMPLE_W-1:0] sample, input logic start);
      int         ih, iv, oh, ov, fh, fv, width, row0, col0, v, h;
      logic       at_end;
      copy_beat_t beat;
      ih = block_count(in_h);
      iv = block_count(in_v);
      oh = block_count(out_h);
      ov = block_count(out_v);
      fh = oh / ih;
      fv = ov / iv;
      width = BLOCK_EDGE * oh;
      if (start) begin
         blk_col = '0;
         blk_row = '0;
         pix_row = '0;
         pix_col = '0;
      end
      row0 = int'(blk_row) * fv * BLOCK_EDGE + int'(pix_row) * fv;
      col0 = int'(blk_col) * fh * BLOCK_EDGE + int'(pix_col) * fh;
      at_end = (int'(blk_row) + 1 >= iv) && (int'(blk_col) + 1 >= ih) &&
               (int'(pix_row) == BLOCK_EDGE - 1) && (int'(pix_col) == BLOCK_EDGE - 1);
      for (v = 0; v < fv; v++) begin
         for (h = 0; h < fh; h++) begin
            beat.address  = ADDR_W'((row0 + v) * width + col0 + h);
            beat.value    = sample;
            beat.run_last = (v == fv - 1) && (h == fh - 1);
            beat.done     = beat.run_last && at_end;
            expected_copies.push_back(beat);
         end
      end
      pix_col = pix_col + 3'd1;
      if (pix_col == '0) begin
         pix_row = pix_row + 3'd1;
         if (pix_row == '0) begin
            // a counter left above a lowered limit wraps on this carry
            if (int'(blk_col) + 1 >= ih) begin
               blk_col = '0;
               if (int'(blk_row) + 1 >= iv) blk_row = '0;
               else blk_row = blk_row + 2'd1;
            end else begin
               blk_col = blk_col + 2'd1;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      copy_beat_t head;
      if (reset) begin
         expected_copies.delete();
         in_h    = REG_W'(1);
         in_v    = REG_W'(1);
         out_h   = REG_W'(1);
         out_v   = REG_W'(1);
         blk_col = '0;
         blk_row = '0;
         pix_row = '0;
         pix_col = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_copies.size() == 0) begin
               mismatches++;
               $display("%0t: copy beat with nothing expected, expected none actual %0h",
                        $time, rsp_tdata);
            end else begin
               head = expected_copies.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== head.address)
                  report_field("out_address", head.address, rsp_tdata[ADDR_W-1:0]);
               if (rsp_tdata[ADDR_W +: SAMPLE_W] !== head.value)
                  report_field("out_value", head.value, rsp_tdata[ADDR_W +: SAMPLE_W]);
               if (rsp_tdata[RDATA_W-1 -: PAD_W] !== '0)
                  report_field("tdata padding", 0, rsp_tdata[RDATA_W-1 -: PAD_W]);
               if (rsp_tlast !== head.run_last)
                  report_field("run_last", head.run_last, rsp_tlast);
               if (rsp_tuser !== head.done)
                  report_field("component_done", head.done, rsp_tuser);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IN_BLOCKS_H:  in_h  = csr_data;
               CSR_IN_BLOCKS_V:  in_v  = csr_data;
               CSR_OUT_BLOCKS_H: out_h = csr_data;
               CSR_OUT_BLOCKS_V: out_v = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_copies(req_tdata, req_tuser);
      end
      outstanding = expected_copies.size();
   end

endmodule

// ----- test/tb_block_to_raster_replicating_upsampler_core.sv -----
`timescale 1ns / 1ps

module tb_block_to_raster_replicating_upsampler_core;
   import bru_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int TAIL_CYCLES  = 24;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [2:0] CSR_UNUSED_FIRST = 3'd4;
   localparam logic [2:0] CSR_UNUSED_LAST  = 3'd7;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid  = 1'b0;
   logic [2:0]           csr_index  = '0;
   logic [REG_W-1:0]     csr_data   = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [RDATA_W-1:0]   rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_ready;

   int mismatches;
   int outstanding;
   int cycles;
   bit idle_on  = 1'b1;
   bit hold_req = 1'b0;

   block_to_raster_replicating_upsampler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bru_copy_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[block_to_raster_replicating_upsampler_core] ERROR");
         $finish;
      end
   end

   // Receiver: ready stretches, random stall bursts, one long hold on request.
   initial begin : receiver
      int stretch;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stretch = $urandom_range(1, 14);
            rsp_tready = 1'b0;
            repeat (stretch - 1) @(negedge clock);
         end else begin
            stretch = $urandom_range(1, 20);
            rsp_tready = 1'b1;
            repeat (stretch - 1) @(negedge clock);
         end
      end
   end

   task automatic send_sample(input logic [7:0] sample, input logic start);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = sample;
      req_tuser  = start;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop valid, wait out every copy, then let zero-copy samples finish.
   task automatic await_idle();
      pause_sender(1);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(input logic [REG_W-1:0] ih, input logic [REG_W-1:0] iv,
                             input logic [REG_W-1:0] oh, input logic [REG_W-1:0] ov);
      await_idle();
      write_csr(CSR_IN_BLOCKS_H, ih);
      write_csr(CSR_IN_BLOCKS_V, iv);
      write_csr(CSR_OUT_BLOCKS_H, oh);
      write_csr(CSR_OUT_BLOCKS_V, ov);
   endtask

   function automatic logic [REG_W-1:0] pick_count();
      if ($urandom_range(0, 3) == 0) return REG_W'($urandom_range(0, (1 << REG_W) - 1));
      return REG_W'($urandom_range(1, MAX_FACTOR));
   endfunction

   task automatic shuffle_counts();
      await_idle();
      if ($urandom_range(0, 3) != 0) write_csr(CSR_IN_BLOCKS_H, pick_count());
      if ($urandom_range(0, 3) != 0) write_csr(CSR_IN_BLOCKS_V, pick_count());
      if ($urandom_range(0, 3) != 0) write_csr(CSR_OUT_BLOCKS_H, pick_count());
      if ($urandom_range(0, 3) != 0) write_csr(CSR_OUT_BLOCKS_V, pick_count());
      if ($urandom_range(0, 5) == 0)
         write_csr(3'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)), 3'($urandom));
   endtask

   initial begin : stimulus
      int  sent;
      int  run_len;
      int  k;
      bit  fresh;
      bit  hold_phase;
      bit  hold_done;
      sent = 0;
      hold_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset counts: one copy per sample
      send_sample(8'h00, 1'b1);
      send_sample(8'hFF, 1'b0);
      send_sample(8'hA5, 1'b0);
      send_sample(8'h5A, 1'b0);
      // sixteen copies per sample
      set_counts(3'd1, 3'd1, 3'd4, 3'd4);
      send_sample(8'hFF, 1'b1);
      send_sample(8'h00, 1'b0);
      send_sample(8'h3C, 1'b0);
      // zero and seven clamp; vertical factor of zero gives no copies
      set_counts(3'd0, 3'd7, 3'd7, 3'd0);
      send_sample(8'h81, 1'b0);
      send_sample(8'h7E, 1'b1);
      send_sample(8'h18, 1'b0);
      // 2x2 replication; writes to unused indexes must not land
      set_counts(3'd2, 3'd1, 3'd4, 3'd2);
      write_csr(CSR_UNUSED_FIRST, 3'd5);
      write_csr(CSR_UNUSED_LAST, 3'd2);
      send_sample(8'h12, 1'b1);
      send_sample(8'hED, 1'b0);
      send_sample(8'h34, 1'b0);
      send_sample(8'hCB, 1'b0);
      // truncating ratio 4/3
      set_counts(3'd3, 3'd3, 3'd4, 3'd4);
      send_sample(8'h55, 1'b0);
      send_sample(8'hAA, 1'b0);
      send_sample(8'h01, 1'b1);
      // horizontal factor of zero
      set_counts(3'd4, 3'd2, 3'd2, 3'd4);
      send_sample(8'h80, 1'b0);
      send_sample(8'h7F, 1'b0);

      // mostly continuous components; counters carry across count changes
      while (sent < RANDOM_ITEMS) begin
         hold_phase = !hold_done && (sent > RANDOM_ITEMS / 3);
         if (hold_phase) begin
            set_counts(3'd1, 3'd1, 3'd2, 3'd2);
            hold_req  = 1'b1;
            hold_done = 1'b1;
            run_len   = 30;
         end else begin
            shuffle_counts();
            run_len = $urandom_range(1, 40);
         end
         if (sent >= RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
         fresh = ($urandom_range(0, 3) == 0);
         for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
            if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
            send_sample(8'($urandom),
                        (k == 0 && fresh) || ($urandom_range(0, 49) == 0));
            sent++;
         end
      end

      pause_sender(1);
      wait (outstanding == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[block_to_raster_replicating_upsampler_core] OK");
      end else begin
         $display("[block_to_raster_replicating_upsampler_core] ERROR");
      end
      $finish;
   end

endmodule
